[rtl/narrow_unknown_cell_cost_unit_assert.svh]
// Assertion macros for the narrow unknown cell cost unit.
`ifndef NARROW_UNKNOWN_CELL_COST_UNIT_ASSERT_SVH
`define NARROW_UNKNOWN_CELL_COST_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define NUCC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset
`define NUCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/nucc_pkg.sv]
// Shared types and constants of the narrow unknown cell cost unit.
`timescale 1ns / 1ps
`default_nettype none
package nucc_pkg;

	// Cell classes held in the grid memory
	localparam logic [1:0] CLS_FREE     = 2'd0;
	localparam logic [1:0] CLS_UNKNOWN  = 2'd1;
	localparam logic [1:0] CLS_OCCUPIED = 2'd2;

	// Input commands
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Occupancy codes of a written cell value
	localparam logic [7:0] VAL_UNKNOWN  = 8'hFF;
	localparam logic [7:0] VAL_OCCUPIED = 8'd100;

	// Register indexes (word address bits)
	localparam logic [2:0] REG_MAP_WIDTH    = 3'd0;
	localparam logic [2:0] REG_MAP_HEIGHT   = 3'd1;
	localparam logic [2:0] REG_UNKNOWN_COST = 3'd2;
	localparam logic [2:0] REG_NARROW_COST  = 3'd3;
	localparam logic [2:0] REG_THRESHOLD    = 3'd4;
	localparam logic [2:0] REG_SCAN_LIMIT   = 3'd5;

	// Scan position: signed, holds -1 up to a map size of 127
	localparam int POS_W = 9;

	// One step along a scan direction
	typedef struct packed {
		logic signed [1:0] dx;
		logic signed [1:0] dy;
	} dir_t;

	// Step of axis a (0 horizontal, 1 vertical, 2 and 3 diagonals), side 0 or 1
	function automatic dir_t axis_dir(input logic [1:0] a, input logic side);
		dir_t d;
		case (a)
			2'd0: d = '{dx: 2'sd1, dy: 2'sd0};
			2'd1: d = '{dx: 2'sd0, dy: 2'sd1};
			2'd2: d = '{dx: 2'sd1, dy: 2'sd1};
			default: d = '{dx: 2'sd1, dy: -2'sd1};
		endcase
		if (side) begin
			d.dx = -d.dx;
			d.dy = -d.dy;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

[rtl/nucc_ram.sv]
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module nucc_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[rtl/narrow_unknown_cell_cost_unit.sv]
// Top level of the narrow unknown cell cost unit.
`timescale 1ns / 1ps
`default_nettype none
// Occupancy grid of MAX_WIDTH x MAX_HEIGHT cells (free, unknown, occupied)
// with a cost query. A write transaction (tuser 0) stores one cell and
// returns nothing; the unit is ready again at once. A query
// (tuser 1) returns one result: cost 0 for a known cell, outside flag for a
// cell beyond the map, else the narrow or unknown cost. The query is served by
// a sequencer around one grid memory read port: for each of the four axes it
// scans the positive side, then the negative side if an occupied cell ended
// the first, one cell at a time (read, evaluate), up to L = max(scan_limit,
// threshold_cells, 1) cells, and a gap test runs on one shared squaring
// multiplier, with a squaring step first on a diagonal. The input is not
// ready while a query is served. A result waits in an output register, so
// a new item is taken while it is unread. The grid memory
// is not cleared after reset: cells must be written before they are scanned.
module narrow_unknown_cell_cost_unit
	import nucc_pkg::*;
#(
	parameter int MAX_WIDTH  = 64,
	parameter int MAX_HEIGHT = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // cell_x[5:0], cell_y[11:6], cell_value[19:12]
	input  wire logic [0:0]  s_axis_tuser,   // command[0]
	// Result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic      [7:0]  m_axis_tdata,   // cost[6:0]
	output logic      [1:0]  m_axis_tuser,   // narrow[0], outside[1]
	// Configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AddrW = $clog2(Depth);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER,
		ST_STEP,
		ST_EVAL,
		ST_GAP,
		ST_GAP_CMP,
		ST_DONE
	} state_t;

	// Grid address of a cell
	function automatic logic [AddrW-1:0] cell_addr(input logic [7:0] x, input logic [7:0] y);
		return AddrW'(32'(y) * MAX_WIDTH + 32'(x));
	endfunction

	// Configuration registers
	logic [6:0] map_w_q, map_h_q, unk_cost_q, nar_cost_q;
	logic [7:0] thr_q, scan_q;

	// Sequencer state
	state_t                   state_q;
	logic [5:0]               qx_q, qy_q;
	logic signed [POS_W-1:0]  pos_x_q, pos_y_q;
	logic [1:0]               axis_q;
	logic                     side_q;
	logic [7:0]               step_q, limit_q, dist_p_q;
	logic [8:0]               sum_q;
	logic [17:0]              sq_q;
	logic [6:0]               res_cost_q;
	logic                     res_narrow_q, res_outside_q;

	// Output register
	logic       out_valid_q;
	logic [6:0] out_cost_q;
	logic       out_narrow_q, out_outside_q;

	// Input fields
	logic       in_cmd;
	logic [5:0] in_x, in_y;
	logic [7:0] in_val;
	logic       in_accept, cfg_we;

	assign in_cmd = s_axis_tuser[0];
	assign in_x   = s_axis_tdata[5:0];
	assign in_y   = s_axis_tdata[11:6];
	assign in_val = s_axis_tdata[19:12];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign pready        = 1'b1;
	assign cfg_we        = psel && penable && pwrite && pready;

	// Effective map size
	logic [6:0] eff_w, eff_h;
	assign eff_w = (32'(map_w_q) > MAX_WIDTH)  ? 7'(MAX_WIDTH)  : map_w_q;
	assign eff_h = (32'(map_h_q) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : map_h_q;

	logic in_outside;
	assign in_outside = ({1'b0, in_x} >= eff_w) || ({1'b0, in_y} >= eff_h);

	// Grid memory
	logic             ram_we, ram_re;
	logic [AddrW-1:0] ram_waddr, ram_raddr;
	logic [1:0]       ram_wdata, ram_rdata;

	assign ram_we    = in_accept && (in_cmd == CMD_WRITE) &&
	                   (32'(in_x) < MAX_WIDTH) && (32'(in_y) < MAX_HEIGHT);
	assign ram_waddr = cell_addr(8'(in_x), 8'(in_y));
	assign ram_wdata = (in_val == VAL_UNKNOWN)  ? CLS_UNKNOWN :
	                   (in_val == VAL_OCCUPIED) ? CLS_OCCUPIED : CLS_FREE;

	assign ram_re    = (state_q == ST_IDLE) || (state_q == ST_STEP);
	assign ram_raddr = (state_q == ST_IDLE) ? cell_addr(8'(in_x), 8'(in_y)) :
	                   cell_addr(8'(pos_x_q[POS_W-2:0]), 8'(pos_y_q[POS_W-2:0]));

	nucc_ram #(
		.WIDTH (2),
		.DEPTH (Depth)
	) u_grid (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Scan geometry
	logic signed [POS_W-1:0] ctr_x, ctr_y;
	dir_t cur_dir, neg_dir, nax_dir;
	logic pos_in_map;

	assign ctr_x   = POS_W'(qx_q);
	assign ctr_y   = POS_W'(qy_q);
	assign cur_dir = axis_dir(axis_q, side_q);
	assign neg_dir = axis_dir(axis_q, 1'b1);
	assign nax_dir = axis_dir(axis_q + 2'd1, 1'b0);
	assign pos_in_map = !pos_x_q[POS_W-1] && !pos_y_q[POS_W-1] &&
	                    (pos_x_q[POS_W-2:0] < (POS_W-1)'(eff_w)) &&
	                    (pos_y_q[POS_W-2:0] < (POS_W-1)'(eff_h));

	// Shared squaring multiplier
	logic [8:0]  mul_a;
	logic [17:0] prod;
	assign mul_a = (state_q == ST_GAP_CMP) ? {1'b0, thr_q} : sum_q;
	assign prod  = mul_a * mul_a;

	// End of one scan direction and outcome of the gap test
	logic       dir_fin, go_next, go_narrow;
	logic [7:0] fin_dist;

	always_comb begin
		dir_fin   = 1'b0;
		fin_dist  = '0;
		go_narrow = 1'b0;
		case (state_q)
			ST_STEP: begin
				dir_fin = !pos_in_map;
			end
			ST_EVAL: begin
				if (ram_rdata == CLS_OCCUPIED) begin
					dir_fin  = 1'b1;
					fin_dist = step_q;
				end else if (step_q == limit_q) begin
					dir_fin = 1'b1;
				end
			end
			ST_GAP: begin
				go_narrow = !axis_q[1] && (sum_q <= {1'b0, thr_q});
			end
			ST_GAP_CMP: begin
				go_narrow = ({sq_q, 1'b0} <= {1'b0, prod});
			end
			default: begin
			end
		endcase
		go_next = (dir_fin && (fin_dist == '0)) ||
		          ((state_q == ST_GAP) && !axis_q[1] && !go_narrow) ||
		          ((state_q == ST_GAP_CMP) && !go_narrow);
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			axis_q        <= '0;
			side_q        <= 1'b0;
			step_q        <= '0;
			limit_q       <= 8'd1;
		end else begin
			if (out_valid_q && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_accept && (in_cmd == CMD_QUERY)) begin
						qx_q          <= in_x;
						qy_q          <= in_y;
						limit_q       <= (thr_q > scan_q) ? thr_q :
						                 (scan_q == '0) ? 8'd1 : scan_q;
						res_cost_q    <= '0;
						res_narrow_q  <= 1'b0;
						res_outside_q <= in_outside;
						state_q       <= in_outside ? ST_DONE : ST_CENTER;
					end
				end
				ST_CENTER: begin
					if (ram_rdata != CLS_UNKNOWN) begin
						state_q <= ST_DONE;
					end else begin
						axis_q  <= 2'd0;
						side_q  <= 1'b0;
						step_q  <= 8'd1;
						pos_x_q <= ctr_x + POS_W'(axis_dir(2'd0, 1'b0).dx);
						pos_y_q <= ctr_y + POS_W'(axis_dir(2'd0, 1'b0).dy);
						state_q <= ST_STEP;
					end
				end
				ST_STEP, ST_EVAL: begin
					if (dir_fin) begin
						if (fin_dist != '0) begin
							if (!side_q) begin
								dist_p_q <= fin_dist;
								side_q   <= 1'b1;
								step_q   <= 8'd1;
								pos_x_q  <= ctr_x + POS_W'(neg_dir.dx);
								pos_y_q  <= ctr_y + POS_W'(neg_dir.dy);
								state_q  <= ST_STEP;
							end else begin
								sum_q   <= 9'(dist_p_q) + 9'(fin_dist);
								state_q <= ST_GAP;
							end
						end
					end else if (state_q == ST_EVAL) begin
						step_q  <= step_q + 8'd1;
						pos_x_q <= pos_x_q + POS_W'(cur_dir.dx);
						pos_y_q <= pos_y_q + POS_W'(cur_dir.dy);
						state_q <= ST_STEP;
					end else begin
						state_q <= ST_EVAL;
					end
				end
				ST_GAP: begin
					// diagonal: square the gap first
					if (axis_q[1]) begin
						sq_q    <= prod;
						state_q <= ST_GAP_CMP;
					end
				end
				ST_GAP_CMP: begin
				end
				ST_DONE: begin
					if (!out_valid_q || m_axis_tready) begin
						out_valid_q   <= 1'b1;
						out_cost_q    <= res_cost_q;
						out_narrow_q  <= res_narrow_q;
						out_outside_q <= res_outside_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Narrow gap found: query done
			if (go_narrow) begin
				res_cost_q   <= nar_cost_q;
				res_narrow_q <= 1'b1;
				state_q      <= ST_DONE;
			end

			// Move on to the next axis, or finish as an ordinary unknown cell
			if (go_next) begin
				if (axis_q == 2'd3) begin
					res_cost_q <= unk_cost_q;
					state_q    <= ST_DONE;
				end else begin
					axis_q  <= axis_q + 2'd1;
					side_q  <= 1'b0;
					step_q  <= 8'd1;
					pos_x_q <= ctr_x + POS_W'(nax_dir.dx);
					pos_y_q <= ctr_y + POS_W'(nax_dir.dy);
					state_q <= ST_STEP;
				end
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_cost_q};
	assign m_axis_tuser  = {out_outside_q, out_narrow_q};

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_w_q    <= 7'd64;
			map_h_q    <= 7'd64;
			unk_cost_q <= 7'd80;
			nar_cost_q <= 7'd90;
			thr_q      <= 8'd10;
			scan_q     <= 8'd20;
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_MAP_WIDTH:    map_w_q    <= pwdata[6:0];
				REG_MAP_HEIGHT:   map_h_q    <= pwdata[6:0];
				REG_UNKNOWN_COST: unk_cost_q <= pwdata[6:0];
				REG_NARROW_COST:  nar_cost_q <= pwdata[6:0];
				REG_THRESHOLD:    thr_q      <= pwdata[7:0];
				REG_SCAN_LIMIT:   scan_q     <= pwdata[7:0];
				default: begin
				end
			endcase
		end
	end

	// Configuration reads
	always_comb begin
		case (paddr[4:2])
			REG_MAP_WIDTH:    prdata = 32'(map_w_q);
			REG_MAP_HEIGHT:   prdata = 32'(map_h_q);
			REG_UNKNOWN_COST: prdata = 32'(unk_cost_q);
			REG_NARROW_COST:  prdata = 32'(nar_cost_q);
			REG_THRESHOLD:    prdata = 32'(thr_q);
			REG_SCAN_LIMIT:   prdata = 32'(scan_q);
			default:          prdata = '0;
		endcase
	end

	// Assertions
`include "narrow_unknown_cell_cost_unit_assert.svh"

	`NUCC_ASSERT_IMPLIES(a_result_from_done, $rose(out_valid_q), $past(state_q) == ST_DONE, "result not from done state")
	`NUCC_ASSERT_IMPLIES(a_narrow_cost, out_valid_q && out_narrow_q, !out_outside_q && (out_cost_q == nar_cost_q), "narrow result inconsistent")
	`NUCC_ASSERT_IMPLIES(a_step_in_limit, (state_q == ST_STEP) || (state_q == ST_EVAL), (step_q != '0) && (step_q <= limit_q), "scan step beyond limit")
	`NUCC_ASSERT_NEXT(a_query_busy, in_accept && (in_cmd == CMD_QUERY), !s_axis_tready, "query accepted but input still ready")

endmodule
`default_nettype wire
